// ===== hdl/spq_pkg.sv =====
// package for the sorted priority queue unit
// types, sizes and opcodes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_INSERT = 2'd0;
   localparam opcode_type OP_REMOVE = 2'd1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] priority_key;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE,
      S_DRAIN
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/spq_ram.sv =====
// simple dual-port entry memory, one write and one registered read per cycle
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none
module spq_ram (
   input  wire                    clock,
   input  wire                    wr_en,
   input  wire [spq_pkg::IDX_W-1:0] wr_addr,
   input  spq_pkg::entry_type     wr_data,
   input  wire [spq_pkg::IDX_W-1:0] rd_addr,
   output spq_pkg::entry_type     rd_data
);
   import spq_pkg::*;
   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
// top level of the sorted priority queue unit: sequencer around one entry memory
// depends on spq_pkg and spq_ram
//
// channel  | direction | handshake                 | payload
// req      | in        | start & !busy             | opcode, item_value, item_priority
// rsp      | out       | rsp_valid (one cycle)     | head_value, head_priority, status, count
//
// empty or full case: no busy, result in the next cycle; peek: busy while the head is read
// insert: reads entries from the tail down, one per cycle, moving each lower one up,
//   then writes the new entry in the gap; remove: shifts each later entry down one place
// the memory port is the limit: one read and one write per cycle
// reset clears the state, the count and rsp_valid; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  spq_pkg::opcode_type    req_opcode,
   input  wire signed [31:0]      req_item_value,
   input  wire signed [31:0]      req_item_priority,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_head_value,
   output logic signed [31:0]     rsp_head_priority,
   output spq_pkg::status_type    rsp_status,
   output logic [4:0]             rsp_entry_count
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   entry_type item_ff, item_in;
   logic rm_ff, rm_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   logic rsp_valid_in;
   entry_type rsp_item_in;
   status_type rsp_status_in;

   spq_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rsp_valid <= rsp_valid_in;
      end
      ptr_ff  <= ptr_in;
      item_ff <= item_in;
      rm_ff   <= rm_in;
      if (rsp_valid_in) begin
         rsp_head_value    <= rsp_item_in.value;
         rsp_head_priority <= rsp_item_in.priority_key;
         rsp_status        <= rsp_status_in;
         rsp_entry_count   <= 5'(count_in);
      end
   end

   assign busy = (state_ff != S_IDLE);

   // insert: ptr walks from the tail; rd_data holds entry ptr-1 in S_SHIFT
   // remove: ptr walks up from 1; rd_data holds entry ptr in S_DRAIN
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      item_in       = item_ff;
      rm_in         = rm_ff;
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(ptr_ff);
      wr_data       = item_ff;
      rd_addr       = '0;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = item_ff;
      rsp_status_in = ST_OK;
      case (state_ff)
         S_IDLE: begin
            item_in.value        = req_item_value;
            item_in.priority_key = req_item_priority;
            rm_in                = (req_opcode == OP_REMOVE);
            if (start) begin
               if (req_opcode == OP_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_item_in   = item_in;
                     rsp_status_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     ptr_in   = '0;
                     state_in = S_PLACE;
                  end else begin
                     ptr_in   = count_ff;
                     rd_addr  = IDX_W'(count_ff - 1'b1);
                     state_in = S_SHIFT;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in           = 1'b1;
                  rsp_item_in.value      = -32'sd1;
                  rsp_item_in.priority_key = '0;
                  rsp_status_in          = ST_EMPTY;
               end else begin
                  rd_addr  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_data is the head
            item_in = rd_data;
            if (rm_ff && count_ff > CNT_W'(1)) begin
               ptr_in   = CNT_W'(1);
               rd_addr  = IDX_W'(1);
               state_in = S_DRAIN;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = rd_data;
               if (rm_ff) count_in = count_ff - 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DRAIN: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ptr_ff - 1'b1);
            wr_data = rd_data;
            if (ptr_ff + 1'b1 < count_ff) begin
               ptr_in  = ptr_ff + 1'b1;
               rd_addr = IDX_W'(ptr_ff + 1'b1);
            end else begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff - 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (rd_data.priority_key < item_ff.priority_key) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               ptr_in  = ptr_ff - 1'b1;
               if (ptr_ff == CNT_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  rd_addr = IDX_W'(ptr_ff - 2'd2);
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en        = 1'b1;
            wr_data      = item_ff;
            rsp_valid_in = 1'b1;
            count_in     = count_ff + 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire
